// ----- rtl/saj_pkg.sv -----
package saj_pkg;

  localparam int MAX_SLOTS = 4;
  localparam int IN_BITS = 72;
  localparam int OUT_BITS = 104;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_PROBE = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic [MAX_SLOTS-1:0] bound;
    logic [MAX_SLOTS*16-1:0] values;
  } req_t;

endpackage

// ----- rtl/solution_anti_join_minus.sv -----
// Anti-join over solution rows. Loads store right-hand rows in a table, a
// probe scans every stored row, one row per cycle through the table's
// registered read port, and emits the left-hand row with its position when
// none matches. A probe holds the back end while it scans and, when it emits
// a row, until that row is taken; loads and restarts do not hold it. A
// two-entry queue lets requests be accepted while a probe is scanning or
// its result waits.
module solution_anti_join_minus #(
  parameter int NUM_SLOTS = 4,
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // req_type, bound_bits, slot_value_0 .. slot_value_3
  input  logic [saj_pkg::IN_BITS-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // kept_bound_bits, kept_value_0 .. kept_value_3, row_position
  output logic [saj_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import saj_pkg::*;

  logic [3:0] shared_mask;
  logic q_valid;
  logic q_ready;
  req_t q_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_mask <= '0;
    end else if (cfg_we) begin
      shared_mask <= cfg_wdata;
    end
  end

  saj_front #(.NUM_SLOTS(NUM_SLOTS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  saj_back #(.NUM_SLOTS(NUM_SLOTS), .TABLE_DEPTH(TABLE_DEPTH),
             .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst(rst), .shared_mask(shared_mask),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule

// ----- rtl/saj_front.sv -----
module saj_front #(
  parameter int NUM_SLOTS = 4,
  parameter int VALUE_BITS = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [saj_pkg::IN_BITS-1:0] in_data,
  output logic q_valid,
  input  logic q_ready,
  output saj_pkg::req_t q_req
);
  import saj_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  req_t queue [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0] fill;
  req_t classified;
  logic push;
  logic pop;

  always_comb begin
    classified = '0;
    classified.kind = in_data[1:0];
    for (int s = 0; s < NUM_SLOTS; s++) begin
      classified.bound[s] = in_data[2 + s];
      classified.values[s*16 +: VALUE_BITS] = in_data[6 + s*16 +: VALUE_BITS];
    end
  end

  assign in_ready = (fill != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_req = queue[rd_ptr];
  assign push = in_valid && in_ready && (in_data[1:0] != REQ_UNUSED);
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end
  end

endmodule

// ----- rtl/saj_back.sv -----
module saj_back #(
  parameter int NUM_SLOTS = 4,
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [3:0] shared_mask,
  input  logic q_valid,
  output logic q_ready,
  input  saj_pkg::req_t q_req,
  output logic out_valid,
  input  logic out_ready,
  output logic [saj_pkg::OUT_BITS-1:0] out_data
);
  import saj_pkg::*;

  localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int ROW_BITS = NUM_SLOTS * (VALUE_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [ROW_BITS-1:0] table_mem [TABLE_DEPTH];
  logic [ROW_BITS-1:0] rd_row;
  logic [1:0] state;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] scan_idx;
  logic rd_pending;
  logic hit;
  logic [31:0] offset;
  logic [NUM_SLOTS-1:0] probe_bound;
  logic [NUM_SLOTS*VALUE_BITS-1:0] probe_values;
  logic [ROW_BITS-1:0] load_row;
  logic row_match;
  logic [NUM_SLOTS-1:0] both;
  logic take;
  logic do_load;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      load_row[s*(VALUE_BITS+1) +: VALUE_BITS] = q_req.values[s*16 +: VALUE_BITS];
      load_row[s*(VALUE_BITS+1) + VALUE_BITS] = q_req.bound[s];
    end
  end

  always_comb begin
    row_match = 1'b1;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      both[s] = shared_mask[s] && probe_bound[s] && rd_row[s*(VALUE_BITS+1) + VALUE_BITS];
      if (both[s] && (rd_row[s*(VALUE_BITS+1) +: VALUE_BITS]
                      != probe_values[s*VALUE_BITS +: VALUE_BITS])) begin
        row_match = 1'b0;
      end
    end
    if (both == '0) begin
      row_match = 1'b0;
    end
  end

  assign q_ready = (state == ST_IDLE);
  assign take = q_valid && q_ready;
  assign do_load = take && (q_req.kind == REQ_LOAD) && (count != CNT_BITS'(TABLE_DEPTH));
  assign out_valid = (state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (do_load) begin
      table_mem[count[ADDR_BITS-1:0]] <= load_row;
    end
    rd_row <= table_mem[scan_idx[ADDR_BITS-1:0]];
  end

  always_comb begin
    out_data = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      out_data[s] = probe_bound[s];
      out_data[4 + s*16 +: VALUE_BITS] = probe_values[s*VALUE_BITS +: VALUE_BITS];
    end
    out_data[68 +: 32] = offset;
  end

  always_ff @(posedge clk) begin
    if (take && q_req.kind == REQ_PROBE) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        probe_bound[s] <= q_req.bound[s];
        probe_values[s*VALUE_BITS +: VALUE_BITS] <= q_req.values[s*16 +: VALUE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      offset <= '0;
      scan_idx <= '0;
      rd_pending <= 1'b0;
      hit <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            unique case (q_req.kind)
              REQ_LOAD: begin
                if (do_load) begin
                  count <= count + 1'b1;
                end
              end
              REQ_RESTART: begin
                count <= '0;
                offset <= '0;
              end
              default: begin
                scan_idx <= '0;
                rd_pending <= 1'b0;
                hit <= 1'b0;
                state <= (count == '0) ? ST_EMIT : ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_pending && row_match) begin
            hit <= 1'b1;
          end
          if (scan_idx < count) begin
            scan_idx <= scan_idx + 1'b1;
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
            state <= (hit || (rd_pending && row_match)) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            offset <= offset + 32'd1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/saj_checker.sv -----
module saj_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result right after reset");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back to back results");

  a_accept_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_axis_tvalid, s_axis_tready}))
    else $error("request handshake unknown");

endmodule

bind solution_anti_join_minus saj_checker u_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// ----- sim/solution_anti_join_minus_tb.sv -----
`timescale 1ns / 100ps

module solution_anti_join_minus_tb;
  import saj_pkg::*;

  localparam int DEPTH = 256;
  localparam int SCAN_WAIT = 4 * (DEPTH + 8);
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [3:0] bound;
    logic [3:0][15:0] vals;
    logic [31:0] pos;
  } kept_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  logic [3:0][15:0] right_vals [DEPTH];
  logic [3:0] right_bnd [DEPTH];
  int unsigned right_cnt = 0;
  logic [31:0] next_pos = '0;
  logic [3:0] shared = '0;
  kept_row_t kept_q[$];
  int errors = 0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  solution_anti_join_minus dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit row_matches(logic [3:0] lb, logic [3:0][15:0] lv, int k);
    logic [3:0] both;
    both = shared & lb & right_bnd[k];
    if (both == 4'd0) return 1'b0;
    for (int s = 0; s < 4; s++)
      if (both[s] && lv[s] != right_vals[k][s]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic apply_request(logic [1:0] kind, logic [3:0] lb, logic [3:0][15:0] lv);
    bit hit;
    kept_row_t r;
    hit = 1'b0;
    case (kind)
      REQ_LOAD: begin
        if (right_cnt < DEPTH) begin
          right_vals[right_cnt] = lv;
          right_bnd[right_cnt] = lb;
          right_cnt++;
        end
      end
      REQ_RESTART: begin
        right_cnt = 0;
        next_pos = '0;
      end
      REQ_PROBE: begin
        for (int k = 0; k < right_cnt; k++)
          if (row_matches(lb, lv, k)) hit = 1'b1;
        if (!hit) begin
          r.bound = lb;
          r.vals = lv;
          r.pos = next_pos;
          kept_q.push_back(r);
          next_pos++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(logic [1:0] kind, logic [3:0] lb, logic [3:0][15:0] lv);
    bit rdy;
    while (!no_idle && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, lv[3], lv[2], lv[1], lv[0], lb, kind};
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    apply_request(kind, lb, lv);
  endtask

  task automatic drain_and_set(logic [3:0] mask);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SCAN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    shared = mask;
  endtask

  function automatic logic [15:0] pick_value();
    if ($urandom_range(3) != 0) return 16'($urandom_range(3));
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    drain_and_set(4'hF);
    send_request(REQ_PROBE, 4'hF, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_request(REQ_LOAD, 4'hF, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_request(REQ_PROBE, 4'hF, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_request(REQ_PROBE, 4'h1, {16'h1234, 16'h1234, 16'h1234, 16'h0000});
    send_request(REQ_PROBE, 4'h1, {16'h1234, 16'h1234, 16'h1234, 16'h0001});
    send_request(REQ_PROBE, 4'h0, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_request(REQ_UNUSED, 4'hF, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_request(REQ_LOAD, 4'h0, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_request(REQ_PROBE, 4'hA, {16'hFFFF, 16'h0005, 16'hFFFF, 16'h0005});
    send_request(REQ_RESTART, 4'h0, '0);
    send_request(REQ_PROBE, 4'h5, {16'h0, 16'hFFFF, 16'h0, 16'hFFFF});
    drain_and_set(4'h0);
    send_request(REQ_LOAD, 4'hF, {16'h7, 16'h7, 16'h7, 16'h7});
    send_request(REQ_PROBE, 4'hF, {16'h7, 16'h7, 16'h7, 16'h7});
    drain_and_set(4'h4);
    send_request(REQ_PROBE, 4'hF, {16'h7, 16'h7, 16'h7, 16'h7});
    send_request(REQ_PROBE, 4'hB, {16'h7, 16'h8, 16'h8, 16'h8});
  endtask

  task automatic test_table_full();
    logic [3:0][15:0] v;
    drain_and_set(4'h1);
    send_request(REQ_RESTART, 4'h0, '0);
    for (int i = 0; i < DEPTH + 3; i++) begin
      v = {16'($urandom), 16'($urandom), 16'($urandom), 16'(i)};
      send_request(REQ_LOAD, 4'h1, v);
    end
    send_request(REQ_PROBE, 4'h1, {16'h0, 16'h0, 16'h0, 16'd255});
    send_request(REQ_PROBE, 4'h1, {16'h0, 16'h0, 16'h0, 16'd256});
    send_request(REQ_PROBE, 4'hF, {16'h0, 16'h0, 16'h0, 16'd300});
    send_request(REQ_RESTART, 4'h0, '0);
  endtask

  task automatic test_random(int count);
    int roll;
    logic [1:0] kind;
    logic [3:0][15:0] v;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) kind = REQ_LOAD;
      else if (roll < 85) kind = REQ_PROBE;
      else if (roll < 95) kind = REQ_RESTART;
      else kind = REQ_UNUSED;
      for (int s = 0; s < 4; s++) v[s] = pick_value();
      send_request(kind, 4'($urandom), v);
    end
  endtask

  always @(posedge clk) begin
    kept_row_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
      if (m_axis_tvalid && m_axis_tready) begin
        got.bound = m_axis_tdata[3:0];
        for (int s = 0; s < 4; s++) got.vals[s] = m_axis_tdata[4 + 16*s +: 16];
        got.pos = m_axis_tdata[99:68];
        if (kept_q.size() == 0) begin
          $error("unexpected kept row, bound %h pos %0d", got.bound, got.pos);
          errors++;
        end else begin
          want = kept_q.pop_front();
          if (got.bound != want.bound) begin
            $error("kept_bound_bits: expected %h, got %h", want.bound, got.bound);
            errors++;
          end
          for (int s = 0; s < 4; s++)
            if (got.vals[s] != want.vals[s]) begin
              $error("kept_value_%0d: expected %h, got %h", s, want.vals[s], got.vals[s]);
              errors++;
            end
          if (got.pos != want.pos) begin
            $error("row_position: expected %0d, got %0d", want.pos, got.pos);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** solution_anti_join_minus: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    drain_and_set(4'hF);
    test_random(200);
    no_idle = 1'b1;
    test_random(100);
    no_idle = 1'b0;
    drain_and_set(4'($urandom));
    test_random(200);
    drain_and_set(4'h3);
    test_random(100);
    drain_and_set(4'h0);
    test_random(50);
    s_axis_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SCAN_WAIT) @(posedge clk);
    if (errors == 0 && kept_q.size() == 0)
      $display("** solution_anti_join_minus: PASSED **");
    else
      $display("** solution_anti_join_minus: FAILED **");
    $finish;
  end

endmodule
